>>> hdl/sphke_pkg.sv
// Shared types, constants and the exp table for the SPH smoothing kernel evaluator.
// Used by every module of the block except sphke_div; depends on nothing.
package sphke_pkg;

   localparam int FRAC_BITS = 16;
   localparam int EXP_DEPTH = 256;
   localparam int EXP_SPAN  = 32;

   localparam int LEN_W  = 24;
   localparam int DIST_W = 24;
   localparam int RES_W  = 32;
   localparam int SQ_W   = 2 * LEN_W;
   localparam int CUBE_W = 3 * LEN_W;
   localparam int QF     = 30;
   localparam int RQ_W   = 35;
   localparam int ROM_AW = $clog2(EXP_DEPTH + 1);
   localparam int POS_W  = RQ_W + ROM_AW;
   localparam int TD_W   = ((2 * RES_W + 1 + 7) >> 3) << 3;

   localparam int K_W    = 31;
   localparam int PV_W   = 31;
   localparam int PS_W   = 34;
   localparam int PROD_W = K_W + PS_W;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_KIND   = 1'b1;

   localparam logic [LEN_W-1:0] LEN_RESET = 24'd65536;
   localparam logic [30:0]      ONE_Q30   = 31'h4000_0000;

   localparam logic [K_W-1:0] C_4_PI   = 31'd341782638;
   localparam logic [K_W-1:0] C_6_PI   = 31'd512673957;
   localparam logic [K_W-1:0] C_12_PI  = 31'd1025347913;
   localparam logic [K_W-1:0] C_24_PI  = 31'd2050695827;
   localparam logic [K_W-1:0] C_1_SQPI = 31'd151448488;
   localparam logic [K_W-1:0] C_2_SQPI = 31'd302896976;

   localparam logic [RES_W-1:0] RES_MAX_POS = 32'h7fff_ffff;
   localparam logic [RES_W-1:0] RES_MAX_NEG = 32'h8000_0000;

   typedef enum logic [1:0] {
      KIND_GAUSS  = 2'd0,
      KIND_CUBIC  = 2'd1,
      KIND_LINEAR = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     ok;
   } ctl_type;

   typedef struct packed {
      logic [LEN_W-1:0]  h;
      logic [SQ_W-1:0]   h2;
      logic [CUBE_W-1:0] h3;
   } hpow_type;

   typedef struct packed {
      logic neg_s;
      logic big_s;
      logic big_v;
   } scale_ctl_type;

   function automatic int num_shift(int k);
      int sh;
      sh = FRAC_BITS * (k + 1);
      return (sh >= 58) ? sh - 58 : 0;
   endfunction

   function automatic int den_shift(int k);
      int sh;
      sh = FRAC_BITS * (k + 1);
      return (sh < 58) ? 58 - sh : 0;
   endfunction

   function automatic int den_width();
      int best;
      int w;
      best = 0;
      for (int k = 1; k <= 3; k++) begin
         w = LEN_W * k + den_shift(k);
         if (w > best) best = w;
      end
      return best;
   endfunction

   localparam int NUM_W = PROD_W + num_shift(3);
   localparam int DEN_W = den_width();

   localparam logic [63:0] TAY_DEP = 64'(EXP_DEPTH);
   localparam logic [63:0] TAY_SPN = 64'(EXP_SPAN);
   localparam logic [63:0] TAY_0  = 64'd1 << 60;
   localparam logic [63:0] TAY_1  = TAY_0  / (TAY_DEP * 64'd1)  * TAY_SPN;
   localparam logic [63:0] TAY_2  = TAY_1  / (TAY_DEP * 64'd2)  * TAY_SPN;
   localparam logic [63:0] TAY_3  = TAY_2  / (TAY_DEP * 64'd3)  * TAY_SPN;
   localparam logic [63:0] TAY_4  = TAY_3  / (TAY_DEP * 64'd4)  * TAY_SPN;
   localparam logic [63:0] TAY_5  = TAY_4  / (TAY_DEP * 64'd5)  * TAY_SPN;
   localparam logic [63:0] TAY_6  = TAY_5  / (TAY_DEP * 64'd6)  * TAY_SPN;
   localparam logic [63:0] TAY_7  = TAY_6  / (TAY_DEP * 64'd7)  * TAY_SPN;
   localparam logic [63:0] TAY_8  = TAY_7  / (TAY_DEP * 64'd8)  * TAY_SPN;
   localparam logic [63:0] TAY_9  = TAY_8  / (TAY_DEP * 64'd9)  * TAY_SPN;
   localparam logic [63:0] TAY_10 = TAY_9  / (TAY_DEP * 64'd10) * TAY_SPN;
   localparam logic [63:0] TAY_11 = TAY_10 / (TAY_DEP * 64'd11) * TAY_SPN;
   localparam logic [63:0] TAY_12 = TAY_11 / (TAY_DEP * 64'd12) * TAY_SPN;
   localparam logic [63:0] TAY_13 = TAY_12 / (TAY_DEP * 64'd13) * TAY_SPN;
   localparam logic [63:0] TAY_14 = TAY_13 / (TAY_DEP * 64'd14) * TAY_SPN;
   localparam logic [63:0] TAY_15 = TAY_14 / (TAY_DEP * 64'd15) * TAY_SPN;
   localparam logic [63:0] TAY_16 = TAY_15 / (TAY_DEP * 64'd16) * TAY_SPN;
   localparam logic [63:0] TAY_17 = TAY_16 / (TAY_DEP * 64'd17) * TAY_SPN;
   localparam logic [63:0] TAY_18 = TAY_17 / (TAY_DEP * 64'd18) * TAY_SPN;
   localparam logic [63:0] TAY_19 = TAY_18 / (TAY_DEP * 64'd19) * TAY_SPN;
   localparam logic [63:0] TAY_20 = TAY_19 / (TAY_DEP * 64'd20) * TAY_SPN;
   localparam logic [63:0] TAY_21 = TAY_20 / (TAY_DEP * 64'd21) * TAY_SPN;
   localparam logic [63:0] TAY_22 = TAY_21 / (TAY_DEP * 64'd22) * TAY_SPN;
   localparam logic [63:0] TAY_23 = TAY_22 / (TAY_DEP * 64'd23) * TAY_SPN;
   localparam logic [63:0] TAY_24 = TAY_23 / (TAY_DEP * 64'd24) * TAY_SPN;

   localparam logic [63:0] TAY_POS = TAY_0 + TAY_2 + TAY_4 + TAY_6 + TAY_8 + TAY_10 +
                                     TAY_12 + TAY_14 + TAY_16 + TAY_18 + TAY_20 +
                                     TAY_22 + TAY_24;
   localparam logic [63:0] TAY_NEG = TAY_1 + TAY_3 + TAY_5 + TAY_7 + TAY_9 + TAY_11 +
                                     TAY_13 + TAY_15 + TAY_17 + TAY_19 + TAY_21 +
                                     TAY_23;
   localparam logic [63:0] E32 = (TAY_POS - TAY_NEG + (64'd1 << 27)) >> 28;

   typedef logic [30:0] exp_rom_type [0:EXP_DEPTH];

   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      logic [63:0] prod;
      rom[0] = ONE_Q30;
      for (int i = 1; i <= EXP_DEPTH; i++) begin
         prod = 64'(rom[i-1]) * E32 + (64'd1 << 31);
         rom[i] = 31'(prod >> 32);
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

endpackage

>>> hdl/sph_smoothing_kernel_eval.sv
// SPH smoothing kernel evaluator top level: CSRs, pipeline and result register.
// Depends on sphke_pkg, sphke_front, sphke_div and sphke_poly.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata[23:0] distance
//  rsp     | out | rsp_tvalid/tready    | tdata[31:0] value, [63:32] slope, [64] saturated
//  csr     | in  | csr_we               | csr_index, csr_wdata
//
// One request per cycle unless a stall on rsp holds the pipeline.
// Path: front, two 35-bit quotient dividers, poly, two 32-bit output dividers.
// Reset is synchronous; it clears valid bits and loads the CSR defaults.
// A stall on rsp holds the whole pipeline; req_tready drops with it.
module sph_smoothing_kernel_eval (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sphke_pkg::DIST_W-1:0]       req_tdata,   // [23:0] distance
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sphke_pkg::TD_W-1:0]         rsp_tdata,   // value, slope, saturated
   input  logic                               csr_we,
   input  logic [sphke_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sphke_pkg::LEN_W-1:0]        csr_wdata
);

   logic [sphke_pkg::LEN_W-1:0] len_ff;
   sphke_pkg::kind_type         kind_ff;
   logic                        en;

   logic                          f_valid;
   logic [sphke_pkg::DIST_W-1:0]  f_x;
   logic [sphke_pkg::SQ_W-1:0]    f_x2;
   sphke_pkg::ctl_type            f_ctl;
   sphke_pkg::hpow_type           f_hp;

   logic                          r_valid, t_valid;
   logic [sphke_pkg::RQ_W-1:0]    r_quo, t_quo;
   logic [$bits(sphke_pkg::ctl_type)-1:0]  r_side;
   logic [$bits(sphke_pkg::hpow_type)-1:0] t_side;

   logic                          p_valid;
   logic [sphke_pkg::NUM_W-1:0]   p_num_v, p_num_s;
   logic [sphke_pkg::DEN_W-1:0]   p_den_v, p_den_s;
   sphke_pkg::scale_ctl_type      p_sc;

   logic                          v_valid, s_valid;
   logic [sphke_pkg::RES_W-1:0]   v_quo, s_quo;
   logic                          v_side;
   logic [1:0]                    s_side;

   logic [sphke_pkg::RES_W-1:0]   lim_s, mag_v, mag_s, slope_in;
   logic                          sat_v, sat_s;

   logic                          rsp_tvalid_ff;
   logic [sphke_pkg::TD_W-1:0]    rsp_tdata_ff;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= sphke_pkg::LEN_RESET;
         kind_ff <= sphke_pkg::KIND_GAUSS;
      end else if (csr_we) begin
         unique case (csr_index)
            sphke_pkg::REG_LENGTH: len_ff <= csr_wdata;
            sphke_pkg::REG_KIND:   kind_ff <= sphke_pkg::kind_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   sphke_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_tvalid && en),
      .in_distance (req_tdata),
      .cfg_length  (len_ff),
      .cfg_kind    (kind_ff),
      .out_valid   (f_valid),
      .out_x       (f_x),
      .out_x2      (f_x2),
      .out_ctl     (f_ctl),
      .out_hp      (f_hp)
   );

   sphke_div #(
      .NUM_W  (sphke_pkg::DIST_W + sphke_pkg::QF),
      .DEN_W  (sphke_pkg::LEN_W),
      .QUO_W  (sphke_pkg::RQ_W),
      .SIDE_W ($bits(sphke_pkg::ctl_type))
   ) u_div_r (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_num    ({f_x, 30'b0}),
      .in_den    (f_hp.h),
      .in_side   (f_ctl),
      .out_valid (r_valid),
      .out_quo   (r_quo),
      .out_side  (r_side)
   );

   sphke_div #(
      .NUM_W  (sphke_pkg::SQ_W + sphke_pkg::QF),
      .DEN_W  (sphke_pkg::SQ_W),
      .QUO_W  (sphke_pkg::RQ_W),
      .SIDE_W ($bits(sphke_pkg::hpow_type))
   ) u_div_t (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_num    ({f_x2, 30'b0}),
      .in_den    (f_hp.h2),
      .in_side   (f_hp),
      .out_valid (t_valid),
      .out_quo   (t_quo),
      .out_side  (t_side)
   );

   sphke_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r_valid && t_valid),
      .in_r      (r_quo),
      .in_t      (t_quo),
      .in_ctl    (sphke_pkg::ctl_type'(r_side)),
      .in_hp     (sphke_pkg::hpow_type'(t_side)),
      .out_valid (p_valid),
      .out_num_v (p_num_v),
      .out_den_v (p_den_v),
      .out_num_s (p_num_s),
      .out_den_s (p_den_s),
      .out_sc    (p_sc)
   );

   sphke_div #(
      .NUM_W  (sphke_pkg::NUM_W),
      .DEN_W  (sphke_pkg::DEN_W),
      .QUO_W  (sphke_pkg::RES_W),
      .SIDE_W (1)
   ) u_div_v (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid),
      .in_num    (p_num_v),
      .in_den    (p_den_v),
      .in_side   (p_sc.big_v),
      .out_valid (v_valid),
      .out_quo   (v_quo),
      .out_side  (v_side)
   );

   sphke_div #(
      .NUM_W  (sphke_pkg::NUM_W),
      .DEN_W  (sphke_pkg::DEN_W),
      .QUO_W  (sphke_pkg::RES_W),
      .SIDE_W (2)
   ) u_div_s (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid),
      .in_num    (p_num_s),
      .in_den    (p_den_s),
      .in_side   ({p_sc.neg_s, p_sc.big_s}),
      .out_valid (s_valid),
      .out_quo   (s_quo),
      .out_side  (s_side)
   );

   always_comb begin
      sat_v    = v_side || (v_quo > sphke_pkg::RES_MAX_POS);
      mag_v    = sat_v ? sphke_pkg::RES_MAX_POS : v_quo;
      lim_s    = s_side[1] ? sphke_pkg::RES_MAX_NEG : sphke_pkg::RES_MAX_POS;
      sat_s    = s_side[0] || (s_quo > lim_s);
      mag_s    = sat_s ? lim_s : s_quo;
      slope_in = s_side[1] ? (sphke_pkg::RES_W'(0) - mag_s) : mag_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= v_valid && s_valid;
      end
      if (en) begin
         rsp_tdata_ff <= sphke_pkg::TD_W'({sat_v || sat_s, slope_in, mag_v});
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTHESIS
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty result register");

   a_quotient_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      r_valid == t_valid)
      else $error("quotient dividers out of step");

   a_output_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      v_valid == s_valid)
      else $error("output dividers out of step");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |->
         rsp_tdata[31:0] == 32'h7fff_ffff || rsp_tdata[63:32] == 32'h7fff_ffff ||
         rsp_tdata[63:32] == 32'h8000_0000)
      else $error("saturated flag without a clamped result");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

>>> hdl/sphke_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Generic widths; uses no package items.
module sphke_div #(
   parameter int NUM_W  = 8,
   parameter int DEN_W  = 8,
   parameter int QUO_W  = 8,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [NUM_W-1:0]  rem_ff   [QUO_W];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [QUO_W-1:0]  quo_ff   [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];
   logic              valid_ff [QUO_W];

   logic [NUM_W-1:0]  rem_stg   [QUO_W];
   logic [DEN_W-1:0]  den_stg   [QUO_W];
   logic [QUO_W-1:0]  quo_stg   [QUO_W];
   logic [SIDE_W-1:0] side_stg  [QUO_W];
   logic              valid_stg [QUO_W];

   logic [NUM_W-1:0]  rem_in [QUO_W];
   logic [QUO_W-1:0]  quo_in [QUO_W];
   logic [CMP_W-1:0]  trial  [QUO_W];
   logic              take   [QUO_W];

   always_comb begin
      rem_stg[0]   = in_num;
      den_stg[0]   = in_den;
      quo_stg[0]   = '0;
      side_stg[0]  = in_side;
      valid_stg[0] = in_valid;
      for (int s = 1; s < QUO_W; s++) begin
         rem_stg[s]   = rem_ff[s-1];
         den_stg[s]   = den_ff[s-1];
         quo_stg[s]   = quo_ff[s-1];
         side_stg[s]  = side_ff[s-1];
         valid_stg[s] = valid_ff[s-1];
      end
   end

   always_comb begin
      for (int s = 0; s < QUO_W; s++) begin
         trial[s] = CMP_W'(den_stg[s]) << (QUO_W - 1 - s);
         take[s]  = CMP_W'(rem_stg[s]) >= trial[s];
         rem_in[s] = take[s] ? NUM_W'(CMP_W'(rem_stg[s]) - trial[s]) : rem_stg[s];
         quo_in[s] = quo_stg[s];
         quo_in[s][QUO_W-1-s] = take[s];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < QUO_W; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_stg[s];
         end
         if (en) begin
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= den_stg[s];
            quo_ff[s]  <= quo_in[s];
            side_ff[s] <= side_stg[s];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

>>> hdl/sphke_front.sv
// Input stages: squares, cube of h and the support test for each request.
// Depends on sphke_pkg.
module sphke_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [sphke_pkg::DIST_W-1:0] in_distance,
   input  logic [sphke_pkg::LEN_W-1:0] cfg_length,
   input  sphke_pkg::kind_type         cfg_kind,
   output logic                        out_valid,
   output logic [sphke_pkg::DIST_W-1:0] out_x,
   output logic [sphke_pkg::SQ_W-1:0]  out_x2,
   output sphke_pkg::ctl_type          out_ctl,
   output sphke_pkg::hpow_type         out_hp
);

   logic [3:0] valid_ff;

   logic [sphke_pkg::DIST_W-1:0] x1_ff, x2r_ff, x3_ff, x4_ff;
   logic [sphke_pkg::LEN_W-1:0]  h1_ff, h2r_ff, h3r_ff, h4_ff;
   sphke_pkg::kind_type          k1_ff, k2_ff, k3_ff, k4_ff;
   logic [sphke_pkg::SQ_W-1:0]   xsq2_ff, xsq3_ff, xsq4_ff;
   logic [sphke_pkg::SQ_W-1:0]   hsq2_ff, hsq3_ff, hsq4_ff;
   logic [sphke_pkg::SQ_W-1:0]   phi3_ff, plo3_ff;
   logic [sphke_pkg::CUBE_W-1:0] hcube4_ff;
   logic                         ok3_ff, ok4_ff;

   logic [sphke_pkg::LEN_W-1:0]  h1_in;
   logic                         gauss_ok, near_ok, ok3_in;

   always_comb begin
      h1_in    = (cfg_length == '0) ? sphke_pkg::LEN_W'(1) : cfg_length;
      gauss_ok = {5'b0, xsq2_ff} < {hsq2_ff, 5'b0};
      near_ok  = x2r_ff < h2r_ff;
      case (k2_ff)
         sphke_pkg::KIND_GAUSS: ok3_in = gauss_ok;
         sphke_pkg::KIND_CUBIC, sphke_pkg::KIND_LINEAR: ok3_in = near_ok;
         default: ok3_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
      if (en) begin
         x1_ff     <= in_distance;
         h1_ff     <= h1_in;
         k1_ff     <= cfg_kind;
         x2r_ff    <= x1_ff;
         h2r_ff    <= h1_ff;
         k2_ff     <= k1_ff;
         xsq2_ff   <= sphke_pkg::SQ_W'(x1_ff) * sphke_pkg::SQ_W'(x1_ff);
         hsq2_ff   <= sphke_pkg::SQ_W'(h1_ff) * sphke_pkg::SQ_W'(h1_ff);
         x3_ff     <= x2r_ff;
         h3r_ff    <= h2r_ff;
         k3_ff     <= k2_ff;
         xsq3_ff   <= xsq2_ff;
         hsq3_ff   <= hsq2_ff;
         ok3_ff    <= ok3_in;
         phi3_ff   <= sphke_pkg::SQ_W'(hsq2_ff[47:24]) * sphke_pkg::SQ_W'(h2r_ff);
         plo3_ff   <= sphke_pkg::SQ_W'(hsq2_ff[23:0]) * sphke_pkg::SQ_W'(h2r_ff);
         x4_ff     <= x3_ff;
         h4_ff     <= h3r_ff;
         k4_ff     <= k3_ff;
         xsq4_ff   <= xsq3_ff;
         hsq4_ff   <= hsq3_ff;
         ok4_ff    <= ok3_ff;
         hcube4_ff <= (sphke_pkg::CUBE_W'(phi3_ff) << 24) + sphke_pkg::CUBE_W'(plo3_ff);
      end
   end

   assign out_valid    = valid_ff[3];
   assign out_x        = x4_ff;
   assign out_x2       = xsq4_ff;
   assign out_ctl.kind = k4_ff;
   assign out_ctl.ok   = ok4_ff;
   assign out_hp.h     = h4_ff;
   assign out_hp.h2    = hsq4_ff;
   assign out_hp.h3    = hcube4_ff;

endmodule

>>> hdl/sphke_poly.sv
// Polynomial and table-interpolated exp stages, kernel constant scaling and
// divisor setup for the output dividers. Depends on sphke_pkg.
module sphke_poly (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [sphke_pkg::RQ_W-1:0]   in_r,
   input  logic [sphke_pkg::RQ_W-1:0]   in_t,
   input  sphke_pkg::ctl_type           in_ctl,
   input  sphke_pkg::hpow_type          in_hp,
   output logic                         out_valid,
   output logic [sphke_pkg::NUM_W-1:0]  out_num_v,
   output logic [sphke_pkg::DEN_W-1:0]  out_den_v,
   output logic [sphke_pkg::NUM_W-1:0]  out_num_s,
   output logic [sphke_pkg::DEN_W-1:0]  out_den_s,
   output sphke_pkg::scale_ctl_type     out_sc
);

   localparam int NW = sphke_pkg::NUM_W;
   localparam int DW = sphke_pkg::DEN_W;

   logic [6:0] valid_ff;
   sphke_pkg::kind_type kind_ff [6];
   logic                ok_ff   [6];
   sphke_pkg::hpow_type hp_ff   [7];

   // stage 1
   logic [32:0]                   r1_ff;
   logic [59:0]                   rr1_ff;
   logic [sphke_pkg::POS_W-1:0]   pos1_ff;
   logic [30:0]                   d1_ff;
   // stage 2
   logic [32:0] r2_ff;
   logic [30:0] u2_ff, a2_ff, diff2_ff, d2_ff;
   logic [29:0] frac2_ff;
   logic [61:0] dsq2_ff;
   // stage 3
   logic [32:0] r3_ff;
   logic [30:0] u3_ff, a3_ff, usq3_ff, pl3_ff, d3_ff;
   logic [59:0] m3_ff;
   // stage 4
   logic [32:0] r4_ff;
   logic [30:0] e4_ff, ucube4_ff, ru4_ff, pl4_ff, d4_ff;
   // stage 5
   logic [30:0] e5_ff, ucube5_ff, ru5_ff, pl5_ff, d5_ff;
   logic [33:0] ge5_ff;
   // stage 6
   logic [sphke_pkg::PROD_W-1:0] nv6_ff, ns6_ff;
   logic vhi6_ff, shi6_ff, neg6_ff;
   // stage 7
   logic [NW-1:0] numv7_ff, nums7_ff;
   logic [DW-1:0] denv7_ff, dens7_ff;
   sphke_pkg::scale_ctl_type sc7_ff;

   logic [sphke_pkg::ROM_AW-1:0] idx, idx1;
   logic [30:0] rom_a, rom_b;
   logic [61:0] usq_full, dsq_unused_hi;
   logic [61:0] ucube_full;
   logic [60:0] ru_full;
   logic [63:0] ge_full;
   logic [59:0] rr_in;
   logic [sphke_pkg::K_W-1:0]  kv, ks;
   logic [sphke_pkg::PV_W-1:0] pv;
   logic [sphke_pkg::PS_W-1:0] ps;
   logic vhi_in, shi_in, neg_in;
   logic [NW-1:0] numv_in, nums_in;
   logic [DW-1:0] denv_in, dens_in;

   always_comb begin
      rr_in = 60'(in_r[29:0]) * 60'(in_r[29:0]);
      idx = pos1_ff[sphke_pkg::POS_W-1:sphke_pkg::RQ_W];
      if (idx >= sphke_pkg::ROM_AW'(sphke_pkg::EXP_DEPTH)) begin
         idx = sphke_pkg::ROM_AW'(sphke_pkg::EXP_DEPTH - 1);
      end
      idx1  = idx + sphke_pkg::ROM_AW'(1);
      rom_a = sphke_pkg::EXP_ROM[idx];
      rom_b = sphke_pkg::EXP_ROM[idx1];
      usq_full      = 62'(u2_ff) * 62'(u2_ff);
      dsq_unused_hi = dsq2_ff;
      ucube_full    = 62'(usq3_ff) * 62'(u3_ff);
      ru_full       = 61'(r3_ff[29:0]) * 61'(usq3_ff);
      ge_full       = 64'(r4_ff) * 64'(e4_ff);
   end

   always_comb begin
      kv = '0;
      ks = '0;
      pv = '0;
      ps = '0;
      vhi_in = 1'b1;
      shi_in = 1'b1;
      neg_in = 1'b0;
      unique case (kind_ff[4])
         sphke_pkg::KIND_GAUSS: begin
            kv = sphke_pkg::C_1_SQPI;
            ks = sphke_pkg::C_2_SQPI;
            pv = e5_ff;
            ps = ge5_ff;
            vhi_in = 1'b0;
            shi_in = 1'b0;
            neg_in = 1'b1;
         end
         sphke_pkg::KIND_CUBIC: begin
            kv = sphke_pkg::C_4_PI;
            ks = sphke_pkg::C_24_PI;
            pv = ucube5_ff;
            ps = sphke_pkg::PS_W'(ru5_ff);
            neg_in = 1'b1;
         end
         sphke_pkg::KIND_LINEAR: begin
            kv = sphke_pkg::C_6_PI;
            ks = sphke_pkg::C_12_PI;
            pv = pl5_ff;
            ps = sphke_pkg::PS_W'(d5_ff);
         end
         default: begin
            pv = '0;
            ps = '0;
         end
      endcase
      if (!ok_ff[4]) begin
         pv = '0;
         ps = '0;
      end
   end

   always_comb begin
      numv_in = vhi6_ff ? NW'(nv6_ff) << sphke_pkg::num_shift(2)
                        : NW'(nv6_ff) << sphke_pkg::num_shift(1);
      denv_in = vhi6_ff ? DW'(hp_ff[5].h2) << sphke_pkg::den_shift(2)
                        : DW'(hp_ff[5].h) << sphke_pkg::den_shift(1);
      nums_in = shi6_ff ? NW'(ns6_ff) << sphke_pkg::num_shift(3)
                        : NW'(ns6_ff) << sphke_pkg::num_shift(2);
      dens_in = shi6_ff ? DW'(hp_ff[5].h3) << sphke_pkg::den_shift(3)
                        : DW'(hp_ff[5].h2) << sphke_pkg::den_shift(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
      if (en) begin
         kind_ff[0] <= in_ctl.kind;
         ok_ff[0]   <= in_ctl.ok;
         hp_ff[0]   <= in_hp;
         for (int s = 1; s < 6; s++) begin
            kind_ff[s] <= kind_ff[s-1];
            ok_ff[s]   <= ok_ff[s-1];
         end
         for (int s = 1; s < 7; s++) begin
            hp_ff[s] <= hp_ff[s-1];
         end
         r1_ff   <= in_r[32:0];
         rr1_ff  <= rr_in;
         pos1_ff <= sphke_pkg::POS_W'(in_t) * sphke_pkg::POS_W'(sphke_pkg::EXP_DEPTH);
         d1_ff   <= sphke_pkg::ONE_Q30 - {1'b0, in_r[29:0]};

         r2_ff    <= r1_ff;
         u2_ff    <= sphke_pkg::ONE_Q30 - {1'b0, rr1_ff[59:30]};
         a2_ff    <= rom_a;
         diff2_ff <= rom_a - rom_b;
         frac2_ff <= pos1_ff[34:5];
         dsq2_ff  <= 62'(d1_ff) * 62'(d1_ff);
         d2_ff    <= d1_ff;

         r3_ff   <= r2_ff;
         u3_ff   <= u2_ff;
         a3_ff   <= a2_ff;
         m3_ff   <= 60'(diff2_ff) * 60'(frac2_ff);
         usq3_ff <= usq_full[60:30];
         pl3_ff  <= dsq_unused_hi[60:30];
         d3_ff   <= d2_ff;

         r4_ff     <= r3_ff;
         e4_ff     <= a3_ff - {1'b0, m3_ff[59:30]};
         ucube4_ff <= ucube_full[60:30];
         ru4_ff    <= ru_full[60:30];
         pl4_ff    <= pl3_ff;
         d4_ff     <= d3_ff;

         e5_ff     <= e4_ff;
         ge5_ff    <= ge_full[63:30];
         ucube5_ff <= ucube4_ff;
         ru5_ff    <= ru4_ff;
         pl5_ff    <= pl4_ff;
         d5_ff     <= d4_ff;

         nv6_ff  <= sphke_pkg::PROD_W'(kv) * sphke_pkg::PROD_W'(pv);
         ns6_ff  <= sphke_pkg::PROD_W'(ks) * sphke_pkg::PROD_W'(ps);
         vhi6_ff <= vhi_in;
         shi6_ff <= shi_in;
         neg6_ff <= neg_in;

         numv7_ff     <= numv_in;
         denv7_ff     <= denv_in;
         nums7_ff     <= nums_in;
         dens7_ff     <= dens_in;
         sc7_ff.big_v <= (DW'(numv_in) >> 32) >= denv_in;
         sc7_ff.big_s <= (DW'(nums_in) >> 32) >= dens_in;
         sc7_ff.neg_s <= neg6_ff;
      end
   end

   assign out_valid = valid_ff[6];
   assign out_num_v = numv7_ff;
   assign out_den_v = denv7_ff;
   assign out_num_s = nums7_ff;
   assign out_den_s = dens7_ff;
   assign out_sc    = sc7_ff;

endmodule

>>> dv/sphke_checker.sv
// Checker for the SPH smoothing kernel evaluator: watches the req, rsp and csr channels,
// predicts each kernel result and compares it whole with the response. Depends on sphke_pkg.
`timescale 1ns / 1ps
module sphke_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [sphke_pkg::DIST_W-1:0]     req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [sphke_pkg::TD_W-1:0]       rsp_tdata,
   input  logic                             csr_we,
   input  logic [sphke_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sphke_pkg::LEN_W-1:0]      csr_wdata,
   output int                               fail_count,
   output int                               pending
);
   import sphke_pkg::*;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] slope;
      logic        sat;
   } kernel_result_t;

   kernel_result_t   kernel_q[$];
   logic [63:0]      exp_tab [0:EXP_DEPTH];
   logic [LEN_W-1:0] cur_length;
   kind_type         cur_kind;

   initial begin
      logic [63:0] term, pos, neg, e32;
      term = 64'd1 << 60;
      pos  = term;
      neg  = 64'd0;
      for (int n = 1; n <= 24; n++) begin
         term = term / (64'(EXP_DEPTH) * 64'(n)) * 64'(EXP_SPAN);
         if (n % 2 == 1) neg = neg + term;
         else pos = pos + term;
      end
      e32 = (pos - neg + (64'd1 << 27)) >> 28;
      exp_tab[0] = 64'd1 << 30;
      for (int i = 1; i <= EXP_DEPTH; i++)
         exp_tab[i] = (exp_tab[i-1] * e32 + (64'd1 << 31)) >> 32;
   end

   function automatic logic [31:0] scale_fixed(logic [63:0] k, logic [63:0] p, int kpow,
                                               logic [63:0] h, logic neg, ref logic sat);
      logic [127:0] w;
      logic [63:0]  n;
      logic [127:0] lim;
      int           sh;
      n   = k * p;
      sh  = FRAC_BITS * (kpow + 1);
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      w   = {64'd0, n} << ((sh >= 58) ? sh - 58 : 0);
      for (int i = 0; i < kpow; i++) w = w / h;
      if (sh < 58) w = w >> (58 - sh);
      if (w > lim) begin
         sat = 1'b1;
         w = lim;
      end
      return neg ? 32'(0) - w[31:0] : w[31:0];
   endfunction

   function automatic kernel_result_t eval_kernel(logic [63:0] x);
      kernel_result_t res;
      logic [63:0]  h, t, pos, idx, frac, e, r, u, u2, u3, d;
      logic [127:0] w;
      logic         sat;
      h   = (cur_length == 0) ? 64'd1 : 64'(cur_length);
      sat = 1'b0;
      res = '0;
      case (cur_kind)
         KIND_GAUSS: begin
            if (x * x < 64'(EXP_SPAN) * h * h) begin
               w    = {64'd0, x * x} << 30;
               w    = w / h / h;
               t    = w[63:0];
               pos  = t * 64'(EXP_DEPTH);
               idx  = pos >> 35;
               if (idx >= EXP_DEPTH) idx = EXP_DEPTH - 1;
               frac = (pos & ((64'd1 << 35) - 1)) >> 5;
               e    = exp_tab[idx] - (((exp_tab[idx] - exp_tab[idx+1]) * frac) >> 30);
               r    = (x << 30) / h;
               res.value = scale_fixed(64'(C_1_SQPI), e, 1, h, 1'b0, sat);
               res.slope = scale_fixed(64'(C_2_SQPI), (r * e) >> 30, 2, h, 1'b1, sat);
            end
         end
         KIND_CUBIC: begin
            if (x < h) begin
               r  = (x << 30) / h;
               u  = (64'd1 << 30) - ((r * r) >> 30);
               u2 = (u * u) >> 30;
               u3 = (u2 * u) >> 30;
               res.value = scale_fixed(64'(C_4_PI), u3, 2, h, 1'b0, sat);
               res.slope = scale_fixed(64'(C_24_PI), (r * u2) >> 30, 3, h, 1'b1, sat);
            end
         end
         KIND_LINEAR: begin
            if (x < h) begin
               d = (64'd1 << 30) - (x << 30) / h;
               res.value = scale_fixed(64'(C_6_PI), (d * d) >> 30, 2, h, 1'b0, sat);
               res.slope = scale_fixed(64'(C_12_PI), d, 3, h, 1'b0, sat);
            end
         end
         default: ;
      endcase
      res.sat = sat;
      return res;
   endfunction

   assign pending = kernel_q.size();

   always @(posedge clock) begin
      logic [71:0]    td;
      kernel_result_t got, want;
      if (reset) begin
         cur_length <= LEN_RESET;
         cur_kind   <= KIND_GAUSS;
         fail_count <= 0;
         kernel_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_LENGTH) cur_length <= csr_wdata;
            else if (csr_index == REG_KIND) cur_kind <= kind_type'(csr_wdata[1:0]);
         end
         if (req_tvalid && req_tready)
            kernel_q.push_back(eval_kernel(64'(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            td        = 72'(rsp_tdata);
            got.value = td[31:0];
            got.slope = td[63:32];
            got.sat   = td[64];
            if (kernel_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result value=%h slope=%h sat=%b",
                           got.value, got.slope, got.sat);
               fail_count <= fail_count + 1;
            end else begin
               want = kernel_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("result: expected %h/%h/%b, got %h/%h/%b",
                              want.value, want.slope, want.sat,
                              got.value, got.slope, got.sat);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> dv/tb_sph_smoothing_kernel_eval.sv
// Testbench top for the SPH smoothing kernel evaluator: clock, reset, request, register
// and rsp back-pressure stimulus, and the verdict. Depends on sphke_pkg and sphke_checker.
`timescale 1ns / 1ps
module tb_sph_smoothing_kernel_eval;
   import sphke_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [DIST_W-1:0]    req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [TD_W-1:0]      rsp_tdata;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEN_W-1:0]     csr_wdata;
   int                   fail_count;
   int                   pending;
   int                   cycles;
   logic                 calm;

   sph_smoothing_kernel_eval i_dut (.*);

   sphke_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("sph_smoothing_kernel_eval: mismatch");
         $finish;
      end
   end

   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 7);
         @(posedge clock);
         if (stall == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
            @(posedge clock);
            rsp_tready <= 1'b1;
         end
         do @(negedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_distance(logic [DIST_W-1:0] x);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [DIST_W-1:0] pick_distance(logic [LEN_W-1:0] h, kind_type kind);
      logic [63:0] span;
      logic [63:0] v;
      span = 64'(h) * ((kind == KIND_GAUSS) ? 6 : 2) + 1;
      case ($urandom_range(0, 9))
         0: v = 64'($urandom);
         1: v = 64'($urandom_range(0, 255));
         2: v = 64'(h) + 64'($urandom_range(0, 2)) - 1;
         default: v = {$urandom, $urandom} % span;
      endcase
      return (v > 64'hff_ffff) ? 24'hff_ffff : v[DIST_W-1:0];
   endfunction

   initial begin
      logic [LEN_W-1:0] h;
      kind_type         kind;
      cycles     = 0;
      calm       = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = REG_LENGTH;
      csr_wdata  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < 3; k++) begin
         kind = kind_type'(k);
         write_csr(REG_KIND, LEN_W'(kind));
         write_csr(REG_LENGTH, LEN_RESET);
         send_distance('0);
         send_distance(24'd1);
         send_distance(24'hff_ffff);
         send_distance(LEN_RESET - 1);
         send_distance(LEN_RESET);
         send_distance(LEN_RESET + 1);
         drain();
      end

      for (int p = 0; p < 15; p++) begin
         kind = kind_type'(p % 3);
         case (p / 3)
            0: h = LEN_RESET;
            1: h = 24'd1;
            2: h = 24'hff_ffff;
            3: h = LEN_W'($urandom_range(1, 24'hff_ffff));
            default: h = LEN_W'($urandom_range(256, 1 << 20));
         endcase
         calm = ($urandom_range(0, 2) == 0);
         write_csr(REG_LENGTH, h);
         write_csr(REG_KIND, LEN_W'(kind));
         repeat (115) send_distance(pick_distance(h, kind));
         drain();
      end

      if (fail_count == 0) begin
         $display("sph_smoothing_kernel_eval: match");
      end else begin
         $display("sph_smoothing_kernel_eval: mismatch");
      end
      $finish;
   end

endmodule
